>>> rtl/core/packed_index_unpacker_defines.svh
// Assertion macros shared by the packed index unpacker RTL.
`ifndef PACKED_INDEX_UNPACKER_DEFINES_SVH
`define PACKED_INDEX_UNPACKER_DEFINES_SVH

`ifndef SYNTH
`define PIU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("piu assertion failed");
`define PIU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("piu assertion failed");
`else
`define PIU_ASSERT_SAME(label, clk, rst, ante, cons)
`define PIU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/core/piu_pkg.sv
// Shared types and constants of the packed index unpacker.
`default_nettype none
package piu_pkg;

   localparam int WORD_BITS      = 64;
   localparam int MAX_ENTRY_BITS = 32;
   localparam int CARRY_BITS     = MAX_ENTRY_BITS - 1;
   localparam int BUF_BITS       = WORD_BITS + CARRY_BITS;
   localparam int COUNT_BITS     = 27;
   localparam int WIDTH_BITS     = 6;
   localparam int AVAIL_BITS     = 7;
   localparam int CC_BITS        = 5;
   localparam int CSR_IDX_BITS   = 1;

   localparam logic [COUNT_BITS-1:0] ENTRY_LIMIT    = 27'd67108864;
   localparam logic [WIDTH_BITS-1:0] MIN_WIDTH      = 6'd2;
   localparam logic [AVAIL_BITS-1:0] WORD_AVAIL     = 7'd64;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PALETTE_SIZE = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ENTRY_COUNT  = 1'd1;

   typedef struct packed {
      logic                      busy;
      logic [WIDTH_BITS-1:0]     width;
      logic [MAX_ENTRY_BITS-1:0] mask;
   } piu_width_status_type;

endpackage
`default_nettype wire

>>> rtl/core/piu_shift.sv
// Shared right shifter used for word loading and entry extraction.
`default_nettype none
module piu_shift
   import piu_pkg::*;
(
   input  wire logic [BUF_BITS-1:0]   data,
   input  wire logic [WIDTH_BITS-1:0] amount,
   output logic [BUF_BITS-1:0]        result
);

   assign result = data >> amount;

endmodule
`default_nettype wire

>>> rtl/core/piu_width.sv
// Iterative ceiling-log2 unit that derives the entry width and mask from the palette size.
`default_nettype none
module piu_width
   import piu_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [MAX_ENTRY_BITS-1:0] palette,
   output piu_width_status_type           status
);

   logic                      busy_ff, busy_in;
   logic [MAX_ENTRY_BITS:0]   probe_ff, probe_in;
   logic [MAX_ENTRY_BITS-1:0] palette_ff, palette_in;
   logic [WIDTH_BITS-1:0]     count_ff, count_in;
   logic [MAX_ENTRY_BITS-1:0] run_mask_ff, run_mask_in;
   logic [WIDTH_BITS-1:0]     width_ff, width_in;
   logic [MAX_ENTRY_BITS-1:0] mask_ff, mask_in;
   logic                      step;

   assign step = (count_ff < WIDTH_BITS'(MAX_ENTRY_BITS)) && (probe_ff < {1'b0, palette_ff});

   always_comb begin
      busy_in     = busy_ff;
      probe_in    = probe_ff;
      palette_in  = palette_ff;
      count_in    = count_ff;
      run_mask_in = run_mask_ff;
      width_in    = width_ff;
      mask_in     = mask_ff;
      if (start) begin
         busy_in     = 1'b1;
         probe_in    = (MAX_ENTRY_BITS+1)'(1);
         palette_in  = palette;
         count_in    = '0;
         run_mask_in = '0;
      end else if (busy_ff) begin
         if (step) begin
            probe_in    = {probe_ff[MAX_ENTRY_BITS-1:0], 1'b0};
            count_in    = count_ff + WIDTH_BITS'(1);
            run_mask_in = {run_mask_ff[MAX_ENTRY_BITS-2:0], 1'b1};
         end else begin
            busy_in = 1'b0;
            if (count_ff < MIN_WIDTH) begin
               width_in = MIN_WIDTH;
               mask_in  = MAX_ENTRY_BITS'(3);
            end else begin
               width_in = count_ff;
               mask_in  = run_mask_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         width_ff <= MIN_WIDTH;
         mask_ff  <= MAX_ENTRY_BITS'(3);
      end else begin
         busy_ff  <= busy_in;
         width_ff <= width_in;
         mask_ff  <= mask_in;
      end
      probe_ff    <= probe_in;
      palette_ff  <= palette_in;
      count_ff    <= count_in;
      run_mask_ff <= run_mask_in;
   end

   assign status.busy  = busy_ff;
   assign status.width = width_ff;
   assign status.mask  = mask_ff;

endmodule
`default_nettype wire

>>> rtl/core/packed_index_unpacker.sv
// Top level of the packed index unpacker: sequencer, carry state and result register.
// Each accepted 64-bit beat is merged with the bits carried over from the previous beat and
// then split into entries of the configured width, one entry per cycle while the output is not
// stalled, through a single shared barrel shifter; a beat passes through a load step, one
// extraction step per entry and a closing step, which carries the truncated result when there
// is one; the entry width is at least two bits. A beat that arrives after the run is complete
// is dropped in its accept cycle. Output stalls stretch the extraction cycles. A write to the
// palette size starts a ceiling-log2 iteration during which neither the configuration port nor
// the input channel is ready. Any configuration write restarts the run.
`default_nettype none
`include "packed_index_unpacker_defines.svh"
module packed_index_unpacker
   import piu_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [WORD_BITS-1:0]      req_word,
   input  wire logic                      req_last_word,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [MAX_ENTRY_BITS-1:0]      rsp_entry,
   output logic                           rsp_truncated,
   output logic                           rsp_run_end,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [MAX_ENTRY_BITS-1:0] csr_data
);

   localparam logic ST_IDLE    = 1'b0;
   localparam logic ST_EXTRACT = 1'b1;

   logic                      state_ff, state_in;
   logic [COUNT_BITS-1:0]     target_ff, target_in;
   logic [COUNT_BITS-1:0]     done_ff, done_in;
   logic [CARRY_BITS-1:0]     carry_ff, carry_in;
   logic [CC_BITS-1:0]        cc_ff, cc_in;
   logic [BUF_BITS-1:0]       buf_ff, buf_in;
   logic [AVAIL_BITS-1:0]     avail_ff, avail_in;
   logic                      last_ff, last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [MAX_ENTRY_BITS-1:0] rsp_entry_ff, rsp_entry_in;
   logic                      rsp_trunc_ff, rsp_trunc_in;
   logic                      rsp_end_ff, rsp_end_in;

   piu_width_status_type      wstat;
   logic                      width_start;
   logic [BUF_BITS-1:0]       shift_data, shift_result;
   logic [WIDTH_BITS-1:0]     shift_amount;
   logic [AVAIL_BITS-1:0]     width_ext, avail_next;
   logic [COUNT_BITS-1:0]     done_next;
   logic                      csr_write, req_accept, out_free, more, next_more;

   assign csr_ready  = (state_ff == ST_IDLE) && !wstat.busy;
   assign csr_write  = csr_valid && csr_ready;
   assign req_stall  = (state_ff != ST_IDLE) || wstat.busy || csr_valid;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign width_start = csr_write && (csr_index == CSR_PALETTE_SIZE);

   piu_width u_width (
      .clock   (clock),
      .reset   (reset),
      .start   (width_start),
      .palette (csr_data),
      .status  (wstat)
   );

   assign shift_data   = (state_ff == ST_IDLE) ? {req_word, CARRY_BITS'(0)} : buf_ff;
   assign shift_amount = (state_ff == ST_IDLE) ?
                         (WIDTH_BITS'(CARRY_BITS) - {1'b0, cc_ff}) : wstat.width;

   piu_shift u_shift (
      .data   (shift_data),
      .amount (shift_amount),
      .result (shift_result)
   );

   assign width_ext  = {1'b0, wstat.width};
   assign avail_next = avail_ff - width_ext;
   assign done_next  = done_ff + COUNT_BITS'(1);
   assign more       = (avail_ff >= width_ext) && (done_ff < target_ff);
   assign next_more  = (avail_next >= width_ext) && (done_next < target_ff);

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      done_in      = done_ff;
      carry_in     = carry_ff;
      cc_in        = cc_ff;
      buf_in       = buf_ff;
      avail_in     = avail_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_entry_in = rsp_entry_ff;
      rsp_trunc_in = rsp_trunc_ff;
      rsp_end_in   = rsp_end_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_PALETTE_SIZE: begin
            end
            CSR_ENTRY_COUNT: begin
               if (csr_data[COUNT_BITS-1:0] > ENTRY_LIMIT) begin
                  target_in = ENTRY_LIMIT;
               end else begin
                  target_in = csr_data[COUNT_BITS-1:0];
               end
            end
            default: begin
            end
         endcase
         done_in  = '0;
         carry_in = '0;
         cc_in    = '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (done_ff < target_ff) begin
                     buf_in   = shift_result | BUF_BITS'(carry_ff);
                     avail_in = WORD_AVAIL + AVAIL_BITS'(cc_ff);
                     last_in  = req_last_word;
                     state_in = ST_EXTRACT;
                  end else if (req_last_word) begin
                     done_in  = '0;
                     carry_in = '0;
                     cc_in    = '0;
                  end
               end
            end
            ST_EXTRACT: begin
               if (more) begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_entry_in = buf_ff[MAX_ENTRY_BITS-1:0] & wstat.mask;
                     rsp_trunc_in = 1'b0;
                     rsp_end_in   = !next_more && !(last_ff && (done_next != target_ff));
                     buf_in       = shift_result;
                     avail_in     = avail_next;
                     done_in      = done_next;
                  end
               end else if (last_ff && (done_ff < target_ff)) begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_entry_in = '0;
                     rsp_trunc_in = 1'b1;
                     rsp_end_in   = 1'b1;
                     done_in      = '0;
                     carry_in     = '0;
                     cc_in        = '0;
                     state_in     = ST_IDLE;
                  end
               end else begin
                  if (last_ff || (done_ff >= target_ff)) begin
                     carry_in = '0;
                     cc_in    = '0;
                  end else begin
                     carry_in = buf_ff[CARRY_BITS-1:0];
                     cc_in    = avail_ff[CC_BITS-1:0];
                  end
                  if (last_ff) begin
                     done_in = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= '0;
         done_ff      <= '0;
         carry_ff     <= '0;
         cc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         done_ff      <= done_in;
         carry_ff     <= carry_in;
         cc_ff        <= cc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      buf_ff       <= buf_in;
      avail_ff     <= avail_in;
      last_ff      <= last_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_trunc_ff <= rsp_trunc_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_entry     = rsp_entry_ff;
   assign rsp_truncated = rsp_trunc_ff;
   assign rsp_run_end   = rsp_end_ff;

   `PIU_ASSERT_SAME(a_trunc_ends_run, clock, reset, rsp_valid && rsp_truncated, rsp_run_end)
   `PIU_ASSERT_SAME(a_trunc_zero, clock, reset, rsp_valid && rsp_truncated, rsp_entry == '0)
   `PIU_ASSERT_SAME(a_busy_stalls, clock, reset, state_ff == ST_EXTRACT || wstat.busy,
                    req_stall && !csr_ready)
   `PIU_ASSERT_NEXT(a_load_extracts, clock, reset,
                    req_accept && !csr_write && (done_ff < target_ff), state_ff == ST_EXTRACT)
   `PIU_ASSERT_SAME(a_carry_below_width, clock, reset, !wstat.busy,
                    {1'b0, cc_ff} < wstat.width)

endmodule
`default_nettype wire
